// ===== hdl/lcrs_pkg.sv =====
// Shared types and constants for the linear concatenation request splitter.
package lcrs_pkg;

  localparam int SECTOR_BYTES  = 512;
  localparam int SECTOR_SHIFT  = 9;
  localparam int MAX_MEMBERS   = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int ADDR_W        = 49;
  localparam int DIV_STEPS     = ADDR_W;
  localparam int DIV_CNT_W     = 6;

  localparam logic [51:0] MEMBER_SIZE_RESET  = 52'd1073741824;
  localparam logic [4:0]  MEMBER_COUNT_RESET = 5'd1;
  localparam logic [51:0] MIN_MEMBER_BYTES   = 52'd512;

  // configuration register indexes
  localparam logic REG_MEMBER_SIZE  = 1'b0;
  localparam logic REG_MEMBER_COUNT = 1'b1;

  typedef struct packed {
    logic [39:0] start_sector;
    logic [15:0] sector_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  member_index;
    logic [51:0] member_offset;
    logic [24:0] segment_bytes;
    logic        last_segment;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } lcrs_cmd_t;

  typedef struct packed {
    logic div_last;
    logic seg_final;
  } lcrs_status_t;

endpackage

// ===== hdl/lcrs_ctrl.sv =====
// Sequencer for the splitter: accept, divide, then emit segments.
module lcrs_ctrl
  import lcrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output lcrs_cmd_t    cmd,
  input  lcrs_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SEG
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.load = in_valid;
      S_DIV:   cmd.div_step = 1'b1;
      S_SEG:   cmd.emit = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_last) state <= S_SEG;
        end
        S_SEG: begin
          if (cmd.emit && status.seg_final) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lcrs_datapath.sv =====
// Datapath: config registers, bit-serial divider and segment formation.
module lcrs_datapath
  import lcrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [51:0]  cfg_data,
  input  in_item_t     in_data,
  input  lcrs_cmd_t    cmd,
  output lcrs_status_t status,
  output out_item_t    out_data
);

  logic [51:0]          member_size;
  logic [4:0]           member_count;
  logic [ADDR_W-1:0]    dividend;
  logic [51:0]          rem;        // remainder, then current offset
  logic [4:0]           quot;       // saturating quotient, then current member
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [24:0]          left;
  logic [3:0]           seg_n;

  logic [51:0] size_eff;
  logic [4:0]  limit;
  logic [52:0] rem_shift;
  logic        rem_ge;
  logic [52:0] rem_diff;
  logic [51:0] rem_next;
  logic [4:0]  quot_next;
  logic [51:0] room;
  logic        left_le_room;
  logic [24:0] len;
  logic        in_range;
  logic        seg_final;
  out_item_t   seg;

  assign size_eff = (member_size < MIN_MEMBER_BYTES) ? MIN_MEMBER_BYTES : member_size;
  assign limit    = (member_count > 5'(MAX_MEMBERS)) ? 5'(MAX_MEMBERS) : member_count;

  // one quotient bit per cycle
  assign rem_shift = {rem, dividend[ADDR_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, size_eff};
  assign rem_diff  = rem_shift - {1'b0, size_eff};
  assign rem_next  = rem_ge ? rem_diff[51:0] : rem_shift[51:0];
  // anything at or above 16 is past every member; pin it at 31
  assign quot_next = quot[4] ? 5'd31 : {quot[3:0], rem_ge};

  assign status.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  assign room         = size_eff - rem;
  assign left_le_room = {27'd0, left} <= room;
  assign len          = left_le_room ? left : room[24:0];
  assign in_range     = quot < limit;

  always_comb begin
    seg = '0;
    seg_final = 1'b1;
    if (!in_range) begin
      seg.segment_bytes = left;
      seg.last_segment  = 1'b1;
      seg.out_of_range  = 1'b1;
    end else if (left == 25'd0) begin
      // empty request: one empty last segment at the start address
      seg.member_index  = quot[3:0];
      seg.member_offset = rem;
      seg.last_segment  = 1'b1;
    end else if (seg_n == 4'(RESULT_LIMIT - 1) && !left_le_room) begin
      seg.segment_bytes = left;
      seg.last_segment  = 1'b1;
      seg.out_of_range  = 1'b1;
    end else begin
      seg.member_index  = quot[3:0];
      seg.member_offset = rem;
      seg.segment_bytes = len;
      seg.last_segment  = left_le_room;
      seg_final         = left_le_room;
    end
  end

  assign status.seg_final = seg_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      member_size  <= MEMBER_SIZE_RESET;
      member_count <= MEMBER_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MEMBER_SIZE:  member_size  <= cfg_data;
        REG_MEMBER_COUNT: member_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend <= {in_data.start_sector, SECTOR_SHIFT'(0)};
      rem      <= '0;
      quot     <= '0;
      div_cnt  <= '0;
      left     <= {in_data.sector_count, SECTOR_SHIFT'(0)};
      seg_n    <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[ADDR_W-2:0], 1'b0};
      rem      <= rem_next;
      quot     <= quot_next;
      div_cnt  <= div_cnt + 1'b1;
    end else if (cmd.emit) begin
      out_data <= seg;
      left     <= left - len;
      quot     <= quot + 1'b1;
      rem      <= '0;
      seg_n    <= seg_n + 1'b1;
    end
  end

endmodule

// ===== hdl/linear_concat_request_splitter.sv =====
// Top level of the linear concatenation request splitter.
//
// Input channel (in_valid/in_stall/in_data) carries one request: a start
// sector and a sector count of 512-byte sectors. The output channel
// (out_valid/out_stall/out_data) carries one or more segments per request,
// each naming a member disk, a byte offset within it and a length; the
// final segment of a request has last_segment set, and a segment past the
// configured members is flagged out_of_range and ends the request.
// The config port writes member_size_bytes (index 0) and member_count
// (index 1) on any cycle cfg_write is high; only write while idle.
// The transfer cycle is followed by bit-serial division of the byte address
// by the member size (one quotient bit per cycle), then by emission of the
// segments, at most 16. The next request is taken once the last segment
// is in the output register, while that segment still waits to be taken.
// A stall on the output holds the current segment and pauses segment
// generation. Reset restores the register defaults (2^30 bytes, one member)
// and empties the output register.
module linear_concat_request_splitter
  import lcrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [51:0] cfg_data
);

  lcrs_cmd_t    cmd;
  lcrs_status_t status;

  lcrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lcrs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the linear concatenation request splitter.
`timescale 1ns / 100ps

module tb_top;
  import lcrs_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_MEMBER_SIZE;
  logic [51:0] cfg_data = '0;

  // geometry as currently programmed into the block
  logic [51:0] geo_size = MEMBER_SIZE_RESET;
  logic [4:0]  geo_count = MEMBER_COUNT_RESET;

  in_item_t  request_q[$];
  out_item_t pending_segments[$];
  logic      drain_hold = 1'b0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  linear_concat_request_splitter DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Split one accepted request into the segments the block must produce.
  task automatic split_request(input in_item_t req);
    logic [63:0] size, members, addr, left, member, offset, room, len;
    out_item_t   seg;
    int          n;
    size = (geo_size < MIN_MEMBER_BYTES) ? 64'(MIN_MEMBER_BYTES) : 64'(geo_size);
    members = (geo_count > MAX_MEMBERS) ? 64'(MAX_MEMBERS) : 64'(geo_count);
    addr = 64'(req.start_sector) << SECTOR_SHIFT;
    left = 64'(req.sector_count) << SECTOR_SHIFT;
    member = addr / size;
    offset = addr % size;
    n = 0;
    if (left == 0) begin
      seg = '0;
      seg.last_segment = 1'b1;
      if (member >= members) begin
        seg.out_of_range = 1'b1;
      end else begin
        seg.member_index = member[3:0];
        seg.member_offset = offset[51:0];
      end
      pending_segments.push_back(seg);
    end
    while (left != 0) begin
      seg = '0;
      room = size - offset;
      len = (left < room) ? left : room;
      // past the members, or a 16th segment that would not finish the request
      if (member >= members || (n == RESULT_LIMIT - 1 && len < left)) begin
        seg.segment_bytes = left[24:0];
        seg.last_segment = 1'b1;
        seg.out_of_range = 1'b1;
        left = 0;
      end else begin
        left = left - len;
        seg.member_index = member[3:0];
        seg.member_offset = offset[51:0];
        seg.segment_bytes = len[24:0];
        seg.last_segment = (left == 0);
        member = member + 1;
        offset = 0;
      end
      pending_segments.push_back(seg);
      n++;
    end
  endtask

  task automatic check_segment(input out_item_t got);
    out_item_t want;
    if (pending_segments.size() == 0) begin
      flag_mismatch($sformatf("segment with none expected: %h", got));
    end else begin
      want = pending_segments.pop_front();
      if (got.member_index !== want.member_index)
        flag_mismatch($sformatf("member_index %0d, expected %0d",
                                got.member_index, want.member_index));
      if (got.member_offset !== want.member_offset)
        flag_mismatch($sformatf("member_offset %0h, expected %0h",
                                got.member_offset, want.member_offset));
      if (got.segment_bytes !== want.segment_bytes)
        flag_mismatch($sformatf("segment_bytes %0d, expected %0d",
                                got.segment_bytes, want.segment_bytes));
      if (got.last_segment !== want.last_segment)
        flag_mismatch($sformatf("last_segment %b, expected %b",
                                got.last_segment, want.last_segment));
      if (got.out_of_range !== want.out_of_range)
        flag_mismatch($sformatf("out_of_range %b, expected %b",
                                got.out_of_range, want.out_of_range));
    end
  endtask

  // Mostly requests placed around member boundaries of the current geometry,
  // some fully random, some at the ends of the address space.
  function automatic in_item_t random_request();
    in_item_t    req;
    logic [63:0] size, off, byte_addr, span;
    int          members;
    int          shape;
    size = (geo_size < MIN_MEMBER_BYTES) ? 64'(MIN_MEMBER_BYTES) : 64'(geo_size);
    members = (geo_count > MAX_MEMBERS) ? MAX_MEMBERS : int'(geo_count);
    shape = $urandom_range(9);
    req.start_sector = 40'({$urandom, $urandom});
    req.sector_count = 16'($urandom);
    if (shape == 1) begin
      req.start_sector = $urandom_range(1) ? '1 : '0;
    end else if (shape >= 2) begin
      off = {$urandom, $urandom} % size;
      case ($urandom_range(2))
        0: off = (size > 64'd2048) ? size - 64'($urandom_range(1, 4)) * SECTOR_BYTES : 64'd0;
        1: off = off % 64'd2048;
        default: ;
      endcase
      byte_addr = 64'($urandom_range(0, members)) * size + off;
      req.start_sector = 40'(byte_addr >> SECTOR_SHIFT);
      if ($urandom_range(3) == 0) span = size * 64'($urandom_range(0, 17));
      else span = size * 64'($urandom_range(0, 2));
      span = span + 64'($urandom_range(0, 4)) * SECTOR_BYTES;
      req.sector_count = ((span >> SECTOR_SHIFT) > 64'hFFFF) ? 16'hFFFF
                                                               : 16'(span >> SECTOR_SHIFT);
      if ($urandom_range(7) == 0) req.sector_count = '0;
    end
    return req;
  endfunction

  task automatic add_request(input logic [39:0] start, input logic [15:0] count);
    in_item_t req;
    req.start_sector = start;
    req.sector_count = count;
    request_q.push_back(req);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) request_q.push_back(random_request());
  endtask

  // sampled away from the rising edge so the sender's updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || pending_segments.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_geometry(input logic [51:0] size, input logic [4:0] count);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_MEMBER_SIZE;
    cfg_data <= size;
    @(posedge clk);
    cfg_index <= REG_MEMBER_COUNT;
    cfg_data <= {junk[51:5], count};  // upper bits are ignored by the block
    @(posedge clk);
    cfg_write <= 1'b0;
    geo_size = size;
    geo_count = count;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drain_hold <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) split_request(in_data);
      if (drain_hold) begin
        // hold off until every outstanding segment has been taken
        in_valid <= 1'b0;
        if (pending_segments.size() == 0) drain_hold <= 1'b0;
      end else if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= request_q.pop_front();
        if ($urandom_range(39) == 0) drain_hold <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) check_segment(out_data);
  end

  // watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: 1 GiB, one member
    add_request(40'd0, 16'd0);
    add_request(40'd0, 16'd1);
    add_request(40'd2097151, 16'd1);
    add_request(40'd2097151, 16'd2);
    add_request(40'd2097152, 16'd0);
    add_request(40'hFF_FFFF_FFFF, 16'hFFFF);
    add_request(40'hFF_FFFF_FFFF, 16'd0);
    add_request(40'd0, 16'hFFFF);
    add_random(40);
    wait_drained();

    // one sector per member: segment limit and member overflow
    set_geometry(52'd512, 5'd16);
    send_idle_pct = 75;
    stall_pct = 0;
    add_request(40'd0, 16'd16);
    add_request(40'd0, 16'd17);
    add_request(40'd5, 16'd20);
    add_request(40'd15, 16'd1);
    add_request(40'd16, 16'd0);
    add_random(55);
    wait_drained();

    // size below minimum, count above maximum
    set_geometry(52'd0, 5'd31);
    send_idle_pct = 0;
    stall_pct = 75;
    add_request(40'd0, 16'd17);
    add_random(50);
    wait_drained();

    set_geometry('1, 5'd2);
    send_idle_pct = 33;
    stall_pct = 33;
    add_request(40'hFF_FFFF_FFFF, 16'hFFFF);
    add_random(40);
    wait_drained();

    // member size not a multiple of the sector
    set_geometry(52'd1000000, 5'd7);
    send_idle_pct = 0;
    stall_pct = 0;
    add_random(55);
    wait_drained();

    set_geometry(52'd1048576, 5'd16);
    send_idle_pct = 75;
    stall_pct = 0;
    add_random(55);
    wait_drained();

    // no members: everything out of range
    set_geometry(52'd1536, 5'd0);
    send_idle_pct = 33;
    stall_pct = 33;
    add_request(40'd0, 16'd0);
    add_request(40'd0, 16'd5);
    add_random(40);
    wait_drained();

    repeat (80) @(posedge clk);
    if (pending_segments.size() != 0)
      flag_mismatch($sformatf("%0d segments never arrived", pending_segments.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lcrs_pkg.sv
hdl/lcrs_ctrl.sv
hdl/lcrs_datapath.sv
hdl/linear_concat_request_splitter.sv
tb/sv/tb_top.sv
